// ===== rtl/sfplf_pkg.sv =====
// ----------------------------------------------------------------------------
// sfplf_pkg
// Shared types, codes and helpers for the SFP port LED and feedback manager.
// ----------------------------------------------------------------------------
`default_nettype none

package sfplf_pkg;

  // request kinds (tuser)
  localparam logic REQ_SERVICE = 1'b0;
  localparam logic REQ_CMD     = 1'b1;

  // command codes
  localparam logic [7:0] CMD_SET_LED  = 8'd1;
  localparam logic [7:0] CMD_FEEDBACK = 8'd2;

  // LED select for set-LED
  localparam logic [7:0] SEL_LINK = 8'd0;
  localparam logic [7:0] SEL_ACT  = 8'd1;

  // feedback ops
  localparam logic [7:0] FB_TX  = 8'd1;
  localparam logic [7:0] FB_RX  = 8'd2;
  localparam logic [7:0] FB_OFF = 8'd3;

  // LED modes
  localparam logic [1:0] MODE_OFF  = 2'd0;
  localparam logic [1:0] MODE_ON   = 2'd1;
  localparam logic [1:0] MODE_SLOW = 2'd2;
  localparam logic [1:0] MODE_FAST = 2'd3;
  localparam logic [7:0] MODE_MAX  = 8'd3;

  // expander addressing
  localparam logic [7:0] MUX_ADDR = 8'h70;
  localparam logic [1:0] REG_OUT  = 2'd1;
  localparam logic [1:0] REG_DIR  = 2'd3;

  // bits of the output byte
  localparam logic [7:0] BIT_FB_TX = 8'h10;
  localparam logic [7:0] BIT_FB_RX = 8'h20;

  // blink counter taps
  localparam int SLOW_TAP = 7;
  localparam int FAST_TAP = 4;

  localparam int MAX_WR = 3;

  typedef struct packed {
    logic       req_type;
    logic [2:0] svc_port;
    logic [7:0] pin_input;
    logic [7:0] cmd_code;
    logic [7:0] cmd_port;
    logic [7:0] cmd_arg;
    logic [7:0] cmd_value;
  } item_t;

  typedef struct packed {
    logic [7:0] dev_addr;
    logic [1:0] reg_select;
    logic [7:0] write_value;
    logic       last;
  } wr_t;

  // write burst produced by one item
  typedef struct packed {
    logic [1:0]            count;
    wr_t  [MAX_WR-1:0]     wr;
  } burst_t;

  function automatic logic led_on(input logic [1:0] mode, input logic [7:0] count);
    logic on;
    case (mode)
      MODE_ON:   on = 1'b1;
      MODE_SLOW: on = count[SLOW_TAP];
      MODE_FAST: on = count[FAST_TAP];
      default:   on = 1'b0;
    endcase
    return on;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/sfplf_engine.sv =====
// ----------------------------------------------------------------------------
// sfplf_engine
// Per-port state and the single-pass update that builds each write burst.
// ----------------------------------------------------------------------------
`default_nettype none

module sfplf_engine #(
  parameter int PORT_COUNT = 8,
  parameter int BASE_ADDR  = 64
) (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    fire,
  input  wire sfplf_pkg::item_t  item,
  output sfplf_pkg::burst_t      burst
);

  localparam int IDX_W = (PORT_COUNT > 1) ? $clog2(PORT_COUNT) : 1;
  localparam logic [8:0] PC = 9'(PORT_COUNT);
  localparam logic [7:0] BASE = 8'(BASE_ADDR);

  logic             ready_flag  [PORT_COUNT];
  logic             prev_detect [PORT_COUNT];
  logic [1:0]       link_mode   [PORT_COUNT];
  logic [1:0]       act_mode    [PORT_COUNT];
  logic [7:0]       blink_count [PORT_COUNT];
  logic [7:0]       out_byte    [PORT_COUNT];

  logic             hit;
  logic [IDX_W-1:0] idx;
  logic [2:0]       port;
  logic             det;
  logic             ready_next, prev_next;
  logic [1:0]       link_next, act_next, mode_w;
  logic [7:0]       count_next, out_next, paddr;

  always_comb begin
    if (item.req_type == sfplf_pkg::REQ_CMD) begin
      hit  = {1'b0, item.cmd_port} < PC;
      port = item.cmd_port[2:0];
    end else begin
      hit  = {6'b0, item.svc_port} < PC;
      port = item.svc_port;
    end
    idx   = port[IDX_W-1:0];
    det   = item.pin_input[7];
    paddr = BASE + {4'b0, port, 1'b0};
    mode_w = (item.cmd_value > sfplf_pkg::MODE_MAX) ? sfplf_pkg::MODE_OFF
                                                     : item.cmd_value[1:0];
  end

  always_comb begin
    ready_next = ready_flag[idx];
    prev_next  = prev_detect[idx];
    link_next  = link_mode[idx];
    act_next   = act_mode[idx];
    count_next = blink_count[idx];
    out_next   = out_byte[idx];
    burst      = '0;
    if (hit) begin
      if (item.req_type == sfplf_pkg::REQ_SERVICE) begin
        if (!ready_flag[idx]) begin
          if (prev_detect[idx] && !det) begin
            ready_next = 1'b1;
          end
          prev_next = det;
        end else begin
          out_next = {out_byte[idx][7:2],
                      sfplf_pkg::led_on(act_mode[idx], blink_count[idx]),
                      sfplf_pkg::led_on(link_mode[idx], blink_count[idx])};
          count_next = blink_count[idx] + 8'd1;
          burst.count             = 2'd1;
          burst.wr[0].dev_addr    = paddr;
          burst.wr[0].reg_select  = sfplf_pkg::REG_OUT;
          burst.wr[0].write_value = out_next;
          burst.wr[0].last        = 1'b1;
        end
      end else begin
        case (item.cmd_code)
          sfplf_pkg::CMD_SET_LED: begin
            if (item.cmd_arg == sfplf_pkg::SEL_LINK) begin
              link_next = mode_w;
            end else if (item.cmd_arg == sfplf_pkg::SEL_ACT) begin
              act_next = mode_w;
            end
          end
          sfplf_pkg::CMD_FEEDBACK: begin
            if (item.cmd_arg == sfplf_pkg::FB_TX || item.cmd_arg == sfplf_pkg::FB_RX) begin
              out_next = out_byte[idx] | ((item.cmd_arg == sfplf_pkg::FB_TX)
                                          ? sfplf_pkg::BIT_FB_TX : sfplf_pkg::BIT_FB_RX);
              burst.count             = 2'd3;
              burst.wr[0].dev_addr    = paddr;
              burst.wr[0].reg_select  = sfplf_pkg::REG_OUT;
              burst.wr[0].write_value = out_next;
              burst.wr[0].last        = 1'b0;
              burst.wr[1].dev_addr    = sfplf_pkg::MUX_ADDR;
              burst.wr[1].reg_select  = sfplf_pkg::REG_DIR;
              burst.wr[1].write_value = 8'h00;
              burst.wr[1].last        = 1'b0;
              burst.wr[2].dev_addr    = sfplf_pkg::MUX_ADDR;
              burst.wr[2].reg_select  = sfplf_pkg::REG_OUT;
              burst.wr[2].write_value = 8'd1 << port[2:1];
              burst.wr[2].last        = 1'b1;
            end else if (item.cmd_arg == sfplf_pkg::FB_OFF) begin
              out_next = out_byte[idx] & ~(sfplf_pkg::BIT_FB_TX | sfplf_pkg::BIT_FB_RX);
              burst.count             = 2'd2;
              burst.wr[0].dev_addr    = paddr;
              burst.wr[0].reg_select  = sfplf_pkg::REG_OUT;
              burst.wr[0].write_value = out_next;
              burst.wr[0].last        = 1'b0;
              burst.wr[1].dev_addr    = sfplf_pkg::MUX_ADDR;
              burst.wr[1].reg_select  = sfplf_pkg::REG_OUT;
              burst.wr[1].write_value = 8'h00;
              burst.wr[1].last        = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PORT_COUNT; i++) begin
        ready_flag[i]  <= 1'b0;
        prev_detect[i] <= 1'b1;
        link_mode[i]   <= sfplf_pkg::MODE_OFF;
        act_mode[i]    <= sfplf_pkg::MODE_OFF;
        blink_count[i] <= 8'd0;
        out_byte[i]    <= 8'd0;
      end
    end else if (fire && hit) begin
      ready_flag[idx]  <= ready_next;
      prev_detect[idx] <= prev_next;
      link_mode[idx]   <= link_next;
      act_mode[idx]    <= act_next;
      blink_count[idx] <= count_next;
      out_byte[idx]    <= out_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/sfplf_wr_seq.sv =====
// ----------------------------------------------------------------------------
// sfplf_wr_seq
// Result register: holds one write burst and plays it out beat by beat.
// ----------------------------------------------------------------------------
`default_nettype none

module sfplf_wr_seq (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    load,
  input  wire sfplf_pkg::burst_t burst,
  output logic                   load_ok,
  output logic                   m_tvalid,
  input  wire                    m_tready,
  output logic [23:0]            m_tdata,
  output logic                   m_tlast
);

  sfplf_pkg::wr_t [sfplf_pkg::MAX_WR-1:0] wbuf;
  logic [1:0]     cnt;
  logic [1:0]     idx;
  logic           busy;
  logic           final_beat;
  sfplf_pkg::wr_t cur;

  always_comb begin
    case (idx)
      2'd0:    cur = wbuf[0];
      2'd1:    cur = wbuf[1];
      default: cur = wbuf[2];
    endcase
  end

  assign final_beat = (idx == cnt - 2'd1);
  assign load_ok    = !busy || (m_tready && final_beat);
  assign m_tvalid   = busy;
  assign m_tdata    = {6'b0, cur.write_value, cur.reg_select, cur.dev_addr};
  assign m_tlast    = cur.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= 2'd0;
      cnt  <= 2'd0;
    end else begin
      if (busy && m_tready) begin
        if (final_beat) begin
          busy <= 1'b0;
        end else begin
          idx <= idx + 2'd1;
        end
      end
      if (load && burst.count != 2'd0) begin
        busy <= 1'b1;
        idx  <= 2'd0;
        cnt  <= burst.count;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && burst.count != 2'd0) begin
      wbuf <= burst.wr;
    end
  end

`ifndef SYNTH
  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> (idx < cnt))
    else $error("write index past burst length");

  a_last_on_final: assert property (@(posedge clk) disable iff (rst)
    busy |-> (m_tlast == final_beat))
    else $error("tlast does not match final beat");

  a_hold_out: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
    else $error("stalled write changed or dropped");
`endif

endmodule

`default_nettype wire

// ===== rtl/sfp_port_led_and_feedback_manager_core.sv =====
// ----------------------------------------------------------------------------
// sfp_port_led_and_feedback_manager_core
// Eight-port SFP detect, LED and TX/RX feedback manager issuing expander writes.
// ----------------------------------------------------------------------------
//
// Channel | Dir | Handshake          | Content
// --------+-----+--------------------+---------------------------------------
// s_*     | in  | s_tvalid/s_tready  | service item or host command
// m_*     | out | m_tvalid/m_tready  | one expander write transaction
//
// An item is registered on accept, evaluated in one pass against the
// per-port state, and its writes (0 to 3) land in the result register when
// that register can take them. The result register drains one write per
// cycle while m_tready is high. A new item is taken while the last write
// of the previous burst is handed off. Reset (rst, synchronous) returns
// every port to detecting, detect pin high, LEDs off, counter and output
// byte zero. Output stalls hold the burst and back up into the input
// register, then s_tready.
// ----------------------------------------------------------------------------
`default_nettype none

module sfp_port_led_and_feedback_manager_core #(
  parameter int PORT_COUNT = 8,
  parameter int BASE_ADDR  = 64
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  // [2:0] svc_port, [10:3] pin_input, [18:11] cmd_code, [26:19] cmd_port,
  // [34:27] cmd_arg, [42:35] cmd_value, [47:43] zero
  input  wire  [47:0] s_tdata,
  // [0] req_type
  input  wire  [0:0]  s_tuser,
  output logic        m_tvalid,
  input  wire         m_tready,
  // [7:0] dev_addr, [9:8] reg_select, [17:10] write_value, [23:18] zero
  output logic [23:0] m_tdata,
  output logic        m_tlast
);

  // input register
  logic              in_valid;
  sfplf_pkg::item_t  in_item;
  logic              fire;
  logic              load_ok;
  sfplf_pkg::burst_t burst;

  assign fire     = in_valid && load_ok;
  assign s_tready = !in_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  // payload only moves on an accepted transaction
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.req_type  <= s_tuser[0];
      in_item.svc_port  <= s_tdata[2:0];
      in_item.pin_input <= s_tdata[10:3];
      in_item.cmd_code  <= s_tdata[18:11];
      in_item.cmd_port  <= s_tdata[26:19];
      in_item.cmd_arg   <= s_tdata[34:27];
      in_item.cmd_value <= s_tdata[42:35];
    end
  end

  // single-pass evaluation against port state
  sfplf_engine #(
    .PORT_COUNT (PORT_COUNT),
    .BASE_ADDR  (BASE_ADDR)
  ) u_engine (
    .clk   (clk),
    .rst   (rst),
    .fire  (fire),
    .item  (in_item),
    .burst (burst)
  );

  // result register, one write per beat
  sfplf_wr_seq u_wr_seq (
    .clk      (clk),
    .rst      (rst),
    .load     (fire),
    .burst    (burst),
    .load_ok  (load_ok),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

`ifndef SYNTH
  // a held item must not be lost or altered while the burst register is busy
  a_hold_item: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !fire) |=> (in_valid && $stable(in_item)))
    else $error("pending item dropped or changed");

  // every accepted transaction lands in the input register
  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> in_valid)
    else $error("accepted item not registered");

  // an empty input register always takes a transaction
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !in_valid |-> s_tready)
    else $error("input stalled while empty");
`endif

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - SFP port LED and feedback manager testbench
// Drives service items and host commands over the input stream. A local
// model of the eight ports tracks detect, LED modes, blink counters and
// output bytes, and queues the expander writes each transaction should cause.
// Every write on the output stream is checked against the oldest queued one.
// ----------------------------------------------------------------------------

module tb;

  localparam int PORTS      = 8;
  localparam int BASE       = 64;
  localparam int HOLD_LEN   = 200;     // receiver hold-off, in cycles
  localparam int LIMIT      = 100000;  // cycle budget for the whole run
  localparam int TAIL       = 20;      // settle time after the last write

  // values outside the defined codes, used to hit the ignore paths
  localparam logic [7:0] CMD_NONE  = 8'd0;
  localparam logic [7:0] CMD_ALL1  = 8'hFF;
  localparam logic [7:0] FB_NONE   = 8'd0;
  localparam logic [7:0] FB_ABOVE  = 8'd4;
  localparam logic [7:0] SEL_OTHER = 8'd7;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [47:0] s_tdata;   // svc_port, pin_input, cmd_code, cmd_port, cmd_arg, cmd_value
  logic [0:0]  s_tuser;   // req_type
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;   // dev_addr, reg_select, write_value
  logic        m_tlast;

  sfp_port_led_and_feedback_manager_core #(
    .PORT_COUNT(PORTS),
    .BASE_ADDR (BASE)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Port model: one entry per port, same reset as the block.
  // --------------------------------------------------------------------------
  logic       sim_ready    [PORTS];
  logic       sim_prev_det [PORTS];
  logic [1:0] sim_link_mode[PORTS];
  logic [1:0] sim_act_mode [PORTS];
  logic [7:0] sim_blink    [PORTS];
  logic [7:0] sim_out_byte [PORTS];

  sfplf_pkg::wr_t pending_writes[$];   // writes still owed by the block, oldest first

  int  err_count   = 0;
  int  item_count  = 0;
  int  write_count = 0;
  int  cycles      = 0;
  bit  gaps_on     = 1'b0;  // sender inserts random idle cycles
  bit  rx_steady   = 1'b1;  // receiver ready except during a hold-off
  bit  hold_req    = 1'b0;  // request for a receiver hold-off
  bit  hold_seen   = 1'b0;
  int  hold_left   = 0;

  function automatic logic [7:0] port_addr(input int p);
    return 8'(BASE + 2 * p);
  endfunction

  function automatic sfplf_pkg::wr_t mk_wr(input logic [7:0] a, input logic [1:0] r,
                                           input logic [7:0] v, input logic l);
    sfplf_pkg::wr_t w;
    w.dev_addr    = a;
    w.reg_select  = r;
    w.write_value = v;
    w.last        = l;
    return w;
  endfunction

  // LED level for a mode, taken from the count before it steps
  function automatic logic led_level(input logic [1:0] mode, input logic [7:0] cnt);
    logic lvl;
    lvl = 1'b0;
    if (mode == sfplf_pkg::MODE_ON)
      lvl = 1'b1;
    else if (mode == sfplf_pkg::MODE_SLOW)
      lvl = cnt[7];
    else if (mode == sfplf_pkg::MODE_FAST)
      lvl = cnt[4];
    return lvl;
  endfunction

  task automatic reset_model();
    for (int i = 0; i < PORTS; i++) begin
      sim_ready[i]     = 1'b0;
      sim_prev_det[i]  = 1'b1;
      sim_link_mode[i] = sfplf_pkg::MODE_OFF;
      sim_act_mode[i]  = sfplf_pkg::MODE_OFF;
      sim_blink[i]     = 8'd0;
      sim_out_byte[i]  = 8'd0;
    end
  endtask

  // Advance the port model by one accepted transaction and queue its writes.
  task automatic predict_writes(input sfplf_pkg::item_t it);
    int         p;
    logic       det;
    logic [1:0] m;
    logic [7:0] leds;
    if (it.req_type == sfplf_pkg::REQ_SERVICE) begin
      p   = it.svc_port;
      det = it.pin_input[7];
      if (!sim_ready[p]) begin
        // detecting: only a falling detect pin matters, nothing is written
        if (sim_prev_det[p] && !det)
          sim_ready[p] = 1'b1;
        sim_prev_det[p] = det;
      end else begin
        leds = {6'd0, led_level(sim_act_mode[p], sim_blink[p]),
                led_level(sim_link_mode[p], sim_blink[p])};
        sim_out_byte[p] = (sim_out_byte[p] & 8'hFC) | leds;
        sim_blink[p]    = sim_blink[p] + 8'd1;
        pending_writes.push_back(mk_wr(port_addr(p), sfplf_pkg::REG_OUT,
                                       sim_out_byte[p], 1'b1));
      end
    end else if (it.cmd_port < PORTS) begin
      p = it.cmd_port;
      if (it.cmd_code == sfplf_pkg::CMD_SET_LED) begin
        m = (it.cmd_value > sfplf_pkg::MODE_MAX) ? sfplf_pkg::MODE_OFF : it.cmd_value[1:0];
        if (it.cmd_arg == sfplf_pkg::SEL_LINK)
          sim_link_mode[p] = m;
        else if (it.cmd_arg == sfplf_pkg::SEL_ACT)
          sim_act_mode[p] = m;
      end else if (it.cmd_code == sfplf_pkg::CMD_FEEDBACK) begin
        if (it.cmd_arg == sfplf_pkg::FB_TX || it.cmd_arg == sfplf_pkg::FB_RX) begin
          sim_out_byte[p] |= (it.cmd_arg == sfplf_pkg::FB_TX) ? sfplf_pkg::BIT_FB_TX
                                                               : sfplf_pkg::BIT_FB_RX;
          pending_writes.push_back(mk_wr(port_addr(p), sfplf_pkg::REG_OUT,
                                         sim_out_byte[p], 1'b0));
          pending_writes.push_back(mk_wr(sfplf_pkg::MUX_ADDR, sfplf_pkg::REG_DIR,
                                         8'h00, 1'b0));
          pending_writes.push_back(mk_wr(sfplf_pkg::MUX_ADDR, sfplf_pkg::REG_OUT,
                                         8'(1 << (p >> 1)), 1'b1));
        end else if (it.cmd_arg == sfplf_pkg::FB_OFF) begin
          sim_out_byte[p] &= ~(sfplf_pkg::BIT_FB_TX | sfplf_pkg::BIT_FB_RX);
          pending_writes.push_back(mk_wr(port_addr(p), sfplf_pkg::REG_OUT,
                                         sim_out_byte[p], 1'b0));
          pending_writes.push_back(mk_wr(sfplf_pkg::MUX_ADDR, sfplf_pkg::REG_OUT,
                                         8'h00, 1'b1));
        end
      end
    end
  endtask

  task automatic flag_error(input string msg);
    err_count++;
    if (err_count <= 10)
      $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  // --------------------------------------------------------------------------
  // Item builders; the fields an item does not use carry random bits.
  // --------------------------------------------------------------------------
  function automatic sfplf_pkg::item_t rand_item();
    return sfplf_pkg::item_t'(44'({$urandom, $urandom}));
  endfunction

  function automatic sfplf_pkg::item_t svc_item(input logic [2:0] port,
                                                input logic [7:0] pin);
    sfplf_pkg::item_t it;
    it           = rand_item();
    it.req_type  = sfplf_pkg::REQ_SERVICE;
    it.svc_port  = port;
    it.pin_input = pin;
    return it;
  endfunction

  function automatic sfplf_pkg::item_t cmd_item(input logic [7:0] code,
                                                input logic [7:0] port,
                                                input logic [7:0] arg,
                                                input logic [7:0] value);
    sfplf_pkg::item_t it;
    it           = rand_item();
    it.req_type  = sfplf_pkg::REQ_CMD;
    it.cmd_code  = code;
    it.cmd_port  = port;
    it.cmd_arg   = arg;
    it.cmd_value = value;
    return it;
  endfunction

  // --------------------------------------------------------------------------
  // Sender: one transaction per call. An idle gap first lowers tvalid; without
  // a gap tvalid stays high and only the payload changes.
  // --------------------------------------------------------------------------
  task automatic send_item(input sfplf_pkg::item_t it);
    if (gaps_on && $urandom_range(0, 99) < 35) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < 35);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= it.req_type;
    s_tdata  <= {5'd0, it.cmd_value, it.cmd_arg, it.cmd_port, it.cmd_code,
                 it.pin_input, it.svc_port};
    do @(posedge clk); while (!s_tready);
    predict_writes(it);
    item_count++;
  endtask

  // Sender goes quiet until the block has delivered every owed write.
  task automatic drain_writes();
    s_tvalid <= 1'b0;
    while (pending_writes.size() != 0)
      @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Receiver: checks each write transaction and paces m_tready. A hold-off
  // request is latched here and counted down one cycle at a time.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : rx_side
    sfplf_pkg::wr_t want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        write_count++;
        if (pending_writes.size() == 0) begin
          flag_error($sformatf("unexpected write addr=%h reg=%0d val=%h last=%b",
                               m_tdata[7:0], m_tdata[9:8], m_tdata[17:10], m_tlast));
        end else begin
          want = pending_writes.pop_front();
          if (m_tdata[7:0] != want.dev_addr || m_tdata[9:8] != want.reg_select ||
              m_tdata[17:10] != want.write_value || m_tlast != want.last)
            flag_error($sformatf({"write mismatch: exp addr=%h reg=%0d val=%h last=%b,",
                                  " got addr=%h reg=%0d val=%h last=%b"},
                                 want.dev_addr, want.reg_select, want.write_value,
                                 want.last, m_tdata[7:0], m_tdata[9:8],
                                 m_tdata[17:10], m_tlast));
        end
      end
    end
    if (hold_req && !hold_seen) begin
      hold_left = HOLD_LEN;
      hold_seen = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (rx_steady) begin
      m_tready <= 1'b1;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= 35);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("Timeout after %0d cycles, %0d writes still owed", cycles,
               pending_writes.size());
      $display("Some tests failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Detecting port: a high pin keeps it detecting, a falling pin makes it
  // ready, and from then on a service writes the output byte.
  task automatic test_detect();
    send_item(svc_item(3'd0, 8'h80));
    send_item(svc_item(3'd0, 8'h7F));
    send_item(svc_item(3'd0, 8'hFF));
  endtask

  // LED modes on a ready port, including a mode above three and a bad select.
  task automatic test_led_modes();
    send_item(cmd_item(sfplf_pkg::CMD_SET_LED, 8'd0, sfplf_pkg::SEL_LINK,
                       8'(sfplf_pkg::MODE_ON)));
    send_item(cmd_item(sfplf_pkg::CMD_SET_LED, 8'd0, sfplf_pkg::SEL_ACT,
                       8'(sfplf_pkg::MODE_FAST)));
    send_item(svc_item(3'd0, 8'h00));
    send_item(cmd_item(sfplf_pkg::CMD_SET_LED, 8'd0, sfplf_pkg::SEL_LINK,
                       8'(sfplf_pkg::MODE_SLOW)));
    send_item(cmd_item(sfplf_pkg::CMD_SET_LED, 8'd0, sfplf_pkg::SEL_ACT, 8'hFF));
    send_item(cmd_item(sfplf_pkg::CMD_SET_LED, 8'd0, SEL_OTHER,
                       8'(sfplf_pkg::MODE_ON)));
    send_item(svc_item(3'd0, 8'h80));
  endtask

  // Feedback on/off, bad ops, out-of-range ports and unknown codes.
  task automatic test_feedback();
    send_item(cmd_item(sfplf_pkg::CMD_FEEDBACK, 8'd0, sfplf_pkg::FB_TX, 8'h00));
    send_item(cmd_item(sfplf_pkg::CMD_FEEDBACK, 8'd7, sfplf_pkg::FB_RX, 8'hFF));
    send_item(cmd_item(sfplf_pkg::CMD_FEEDBACK, 8'd7, sfplf_pkg::FB_OFF, 8'h55));
    send_item(cmd_item(sfplf_pkg::CMD_FEEDBACK, 8'd3, FB_NONE, 8'h00));
    send_item(cmd_item(sfplf_pkg::CMD_FEEDBACK, 8'd3, FB_ABOVE, 8'h00));
    send_item(cmd_item(sfplf_pkg::CMD_FEEDBACK, 8'd8, sfplf_pkg::FB_TX, 8'h00));
    send_item(cmd_item(sfplf_pkg::CMD_FEEDBACK, 8'hFF, sfplf_pkg::FB_RX, 8'h00));
    send_item(cmd_item(CMD_NONE, 8'd1, sfplf_pkg::FB_TX, 8'h01));
    send_item(cmd_item(CMD_ALL1, 8'd1, sfplf_pkg::FB_TX, 8'h01));
  endtask

  // Receiver holds off while the sender keeps pushing three-write commands,
  // so the block backs up and stalls its input.
  task automatic test_backpressure();
    gaps_on   = 1'b0;
    rx_steady = 1'b1;
    hold_req  = 1'b1;
    for (int i = 0; i < 16; i++)
      send_item(cmd_item(sfplf_pkg::CMD_FEEDBACK, 8'($urandom_range(0, PORTS - 1)),
                         ($urandom_range(0, 1) != 0) ? sfplf_pkg::FB_TX
                                                     : sfplf_pkg::FB_RX,
                         8'($urandom)));
    drain_writes();
  endtask

  // Mixed traffic: mostly well-formed, some noise. The first stretch runs
  // without idle cycles on either side.
  task automatic test_random(input int n);
    int         r;
    logic [7:0] pin;
    logic [7:0] port;
    logic [7:0] arg;
    logic [7:0] value;
    for (int i = 0; i < n; i++) begin
      if (i == 60) begin
        gaps_on   = 1'b1;
        rx_steady = 1'b0;
      end
      r = $urandom_range(0, 99);
      if (r < 45) begin
        pin = 8'($urandom);
        if ($urandom_range(0, 99) < 70)
          pin[7] = 1'b0;
        send_item(svc_item(3'($urandom), pin));
      end else if (r < 65) begin
        port  = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, PORTS - 1));
        arg   = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 1));
        value = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
        send_item(cmd_item(sfplf_pkg::CMD_SET_LED, port, arg, value));
      end else if (r < 85) begin
        port = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, PORTS - 1));
        arg  = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(1, 3));
        send_item(cmd_item(sfplf_pkg::CMD_FEEDBACK, port, arg, 8'($urandom)));
      end else begin
        send_item(rand_item());
      end
    end
  endtask

  // Long service run on one port so the counter passes its slow tap and may
  // wrap; the modes swap halfway through.
  task automatic test_blink(input int n);
    logic [2:0] p;
    p = 3'($urandom_range(0, PORTS - 1));
    send_item(svc_item(p, 8'h00));
    send_item(cmd_item(sfplf_pkg::CMD_SET_LED, 8'(p), sfplf_pkg::SEL_LINK,
                       8'(sfplf_pkg::MODE_SLOW)));
    send_item(cmd_item(sfplf_pkg::CMD_SET_LED, 8'(p), sfplf_pkg::SEL_ACT,
                       8'(sfplf_pkg::MODE_FAST)));
    for (int i = 0; i < n; i++) begin
      if (i == n / 2) begin
        send_item(cmd_item(sfplf_pkg::CMD_SET_LED, 8'(p), sfplf_pkg::SEL_LINK,
                           8'(sfplf_pkg::MODE_FAST)));
        send_item(cmd_item(sfplf_pkg::CMD_SET_LED, 8'(p), sfplf_pkg::SEL_ACT,
                           8'(sfplf_pkg::MODE_SLOW)));
      end
      send_item(svc_item(p, 8'($urandom)));
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tuser  <= sfplf_pkg::REQ_SERVICE;
    reset_model();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_detect();
    test_led_modes();
    test_feedback();
    drain_writes();
    test_backpressure();
    test_random(100);
    test_blink(140);
    drain_writes();
    repeat (TAIL) @(posedge clk);

    if (pending_writes.size() != 0)
      flag_error($sformatf("%0d expected writes never arrived", pending_writes.size()));

    $display("Ran %0d transactions: port detect, LED modes and blink taps, TX/RX feedback,",
             item_count);
    $display("ignored ports/codes, a %0d-cycle receiver hold-off; %0d writes checked",
             HOLD_LEN, write_count);
    if (err_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d errors", err_count);
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
